// ===== rtl/sostp_pkg.sv =====
// ----------------------------------------------------------------------------
// sostp_pkg: shared types and constants
// Field widths and sequencer state encoding for the prime table unit.
// ----------------------------------------------------------------------------
package sostp_pkg;

	// word field widths
	localparam int unsigned INDEX_W = 11;
	localparam int unsigned PRIME_W = 14;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_READ,
		ST_CHECK,
		ST_SQUARE,
		ST_MARK,
		ST_NEXT,
		ST_LOOKUP,
		ST_RESP
	} seq_state_t;

endpackage

// ===== rtl/sum_of_two_squares_prime_table_unit.sv =====
// ----------------------------------------------------------------------------
// sum_of_two_squares_prime_table_unit: prime table lookup
// Returns the n-th prime below LIMIT that is a sum of two squares.
// ----------------------------------------------------------------------------
// First query after reset: one-time build that clears the bitmap, then reads and
//   checks each candidate, squares each prime and strikes its multiples.
// Later queries: accept, list read and result load, limited by the registered
//   read of the prime list memory; the result load waits on result_stall.
// Reset (arst_n low) empties the table; the bitmap clearing pass runs at the
//   start of each build.
// ----------------------------------------------------------------------------
module sum_of_two_squares_prime_table_unit #(
	parameter int unsigned LIMIT      = 16384,
	parameter int unsigned LIST_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          query_valid,
	output logic                          query_stall,
	input  logic [sostp_pkg::INDEX_W-1:0] query_index,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [sostp_pkg::PRIME_W-1:0] prime_value,
	output logic                          found
);
	import sostp_pkg::*;

	logic                          map_we;
	logic [$clog2(LIMIT)-1:0]      map_waddr;
	logic                          map_wdata;
	logic [$clog2(LIMIT)-1:0]      map_raddr;
	logic                          map_rdata;
	logic                          list_we;
	logic [$clog2(LIST_DEPTH)-1:0] list_waddr;
	logic [PRIME_W-1:0]            list_wdata;
	logic [$clog2(LIST_DEPTH)-1:0] list_raddr;
	logic [PRIME_W-1:0]            list_rdata;

	// sequencer
	sostp_ctrl #(
		.LIMIT      (LIMIT),
		.LIST_DEPTH (LIST_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.query_valid  (query_valid),
		.query_stall  (query_stall),
		.query_index  (query_index),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.prime_value  (prime_value),
		.found        (found),
		.map_we       (map_we),
		.map_waddr    (map_waddr),
		.map_wdata    (map_wdata),
		.map_raddr    (map_raddr),
		.map_rdata    (map_rdata),
		.list_we      (list_we),
		.list_waddr   (list_waddr),
		.list_wdata   (list_wdata),
		.list_raddr   (list_raddr),
		.list_rdata   (list_rdata)
	);

	// composite bitmap
	sostp_ram #(
		.DEPTH (LIMIT),
		.WIDTH (1)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// prime list
	sostp_ram #(
		.DEPTH (LIST_DEPTH),
		.WIDTH (PRIME_W)
	) u_list (
		.clk   (clk),
		.we    (list_we),
		.waddr (list_waddr),
		.wdata (list_wdata),
		.raddr (list_raddr),
		.rdata (list_rdata)
	);

endmodule

// ===== rtl/sostp_ram.sv =====
// ----------------------------------------------------------------------------
// sostp_ram: simple dual-port memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sostp_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/sostp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sostp_ctrl: sieve and lookup sequencer
// Clears the composite bitmap, walks the sieve with one shared adder and a
// squaring multiplier, appends matching primes, then answers lookups.
// ----------------------------------------------------------------------------
module sostp_ctrl #(
	parameter int unsigned LIMIT      = 16384,
	parameter int unsigned LIST_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// query word
	input  logic                              query_valid,
	output logic                              query_stall,
	input  logic [sostp_pkg::INDEX_W-1:0]     query_index,
	// result word
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [sostp_pkg::PRIME_W-1:0]     prime_value,
	output logic                              found,
	// composite bitmap port
	output logic                              map_we,
	output logic [$clog2(LIMIT)-1:0]          map_waddr,
	output logic                              map_wdata,
	output logic [$clog2(LIMIT)-1:0]          map_raddr,
	input  logic                              map_rdata,
	// prime list port
	output logic                              list_we,
	output logic [$clog2(LIST_DEPTH)-1:0]     list_waddr,
	output logic [sostp_pkg::PRIME_W-1:0]     list_wdata,
	output logic [$clog2(LIST_DEPTH)-1:0]     list_raddr,
	input  logic [sostp_pkg::PRIME_W-1:0]     list_rdata
);
	import sostp_pkg::*;

	localparam int unsigned AW = $clog2(LIMIT);
	localparam int unsigned IW = $clog2(LIMIT + 1);
	localparam int unsigned MW = IW + 1;
	localparam int unsigned LW = $clog2(LIST_DEPTH);
	localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
	localparam int unsigned QW = INDEX_W;

	seq_state_t state_q, state_d;

	logic [IW-1:0]        i_q;
	logic [MW-1:0]        m_q;
	logic [2*IW-1:0]      sq_q;
	logic [CW-1:0]        count_q;
	logic                 built_q;
	logic [QW-1:0]        idx_q;
	logic                 hit_q;
	logic                 result_valid_q;
	logic [PRIME_W-1:0]   prime_value_q;
	logic                 found_q;

	// shared adder: i+1 while scanning, m+i while marking multiples
	logic [MW-1:0] add_a, add_b, sum;
	logic          sum_done;
	logic          is_match, append;
	logic          out_free;
	logic          hit;
	logic [QW-1:0] idx_m1;
	logic [QW+LW-1:0]     idx_ext;
	logic [IW+PRIME_W-1:0] prime_ext;

	always_comb begin
		add_a = {1'b0, i_q};
		add_b = MW'(1);
		if (state_q == ST_MARK) begin
			add_a = m_q;
			add_b = {1'b0, i_q};
		end
	end
	assign sum      = add_a + add_b;
	assign sum_done = (sum >= MW'(LIMIT));

	// prime is kept when it is 2 or one above a multiple of four
	assign is_match = (i_q == IW'(2)) || (i_q[1:0] == 2'b01);
	assign append   = !map_rdata && is_match && (count_q < CW'(LIST_DEPTH));

	// lookup hit: index in one..count, taken once the table is built
	assign hit = (idx_q != '0)
		&& ({{CW{1'b0}}, idx_q} <= {{QW{1'b0}}, count_q});

	assign idx_m1  = idx_q - QW'(1);
	assign idx_ext = {{LW{1'b0}}, idx_m1};
	assign prime_ext = {{PRIME_W{1'b0}}, i_q};

	assign out_free = !result_valid_q || !result_stall;

	// memory ports
	assign map_we     = (state_q == ST_CLEAR) || (state_q == ST_MARK);
	assign map_waddr  = (state_q == ST_MARK) ? m_q[AW-1:0] : i_q[AW-1:0];
	assign map_wdata  = (state_q == ST_MARK);
	assign map_raddr  = i_q[AW-1:0];
	assign list_we    = (state_q == ST_CHECK) && append;
	assign list_waddr = count_q[LW-1:0];
	assign list_wdata = prime_ext[PRIME_W-1:0];
	assign list_raddr = idx_ext[LW-1:0];

	assign query_stall  = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign prime_value  = prime_value_q;
	assign found        = found_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (query_valid) begin
					state_d = built_q ? ST_LOOKUP : ST_CLEAR;
				end
			end
			ST_CLEAR:  if (sum_done) state_d = ST_READ;
			ST_READ:   state_d = ST_CHECK;
			ST_CHECK:  state_d = map_rdata ? ST_NEXT : ST_SQUARE;
			ST_SQUARE: state_d = (sq_q < (2*IW)'(LIMIT)) ? ST_MARK : ST_NEXT;
			ST_MARK:   if (sum_done) state_d = ST_NEXT;
			ST_NEXT:   state_d = sum_done ? ST_LOOKUP : ST_READ;
			ST_LOOKUP: state_d = ST_RESP;
			ST_RESP:   if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			built_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_IDLE && query_valid && !built_q) begin
				count_q <= '0;
			end
			if (state_q == ST_CHECK && append) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_NEXT && sum_done) begin
				built_q <= 1'b1;
			end
			if (state_q == ST_RESP && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (query_valid) begin
					idx_q <= query_index;
					i_q   <= '0;
				end
			end
			ST_CLEAR: begin
				i_q <= sum_done ? IW'(2) : sum[IW-1:0];
			end
			ST_CHECK: begin
				sq_q <= i_q * i_q;
			end
			ST_SQUARE: begin
				m_q <= sq_q[MW-1:0];
			end
			ST_MARK: begin
				m_q <= sum;
			end
			ST_NEXT: begin
				i_q <= sum[IW-1:0];
			end
			ST_LOOKUP: begin
				hit_q <= hit;
			end
			ST_RESP: begin
				if (out_free) begin
					prime_value_q <= hit_q ? list_rdata : '0;
					found_q       <= hit_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
